FILE: rtl/core/hhpc_pkg.sv
// Height histogram plane classifier: shared types, register codes and constants.
// Used by hhpc_div, hhpc_mem and height_histogram_plane_classifier.
// No dependencies.
package hhpc_pkg;

   localparam int HEIGHT_BITS    = 24;
   localparam int NORMAL_BITS    = 16;
   localparam int WIDTH_BITS     = 16;
   localparam int OFFSET_BITS    = 10;
   localparam int INUSE_BITS     = 10;
   localparam int COS_BITS       = 16;
   localparam int MIN_COUNT_BITS = 24;
   localparam int INDEX_OUT_BITS = 9;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // signed floor quotient of a height by the bin width, and a bin number
   localparam int QUO_BITS       = HEIGHT_BITS + 1;
   localparam int BIN_BITS       = HEIGHT_BITS + 2;
   localparam int DIV_CNT_BITS   = $clog2(HEIGHT_BITS);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIN_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_BINS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINS_IN_USE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COS_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_COUNT   = 3'd4;

   // register reset values
   localparam logic [WIDTH_BITS-1:0]            RST_BIN_WIDTH   = 16'd5000;
   localparam logic signed [OFFSET_BITS-1:0]    RST_OFFSET_BINS = 10'sd200;
   localparam logic [INUSE_BITS-1:0]            RST_BINS_IN_USE = 10'd400;
   localparam logic signed [COS_BITS-1:0]       RST_COS_LIMIT   = 16'sd32449;
   localparam logic [MIN_COUNT_BITS-1:0]        RST_MIN_COUNT   = 24'd6000;

   // item kinds
   localparam logic KIND_ACCUMULATE = 1'b0;
   localparam logic KIND_CLASSIFY   = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic signed [HEIGHT_BITS-1:0] height;
      logic signed [NORMAL_BITS-1:0] normal_up;
   } req_type;

   typedef struct packed {
      logic                      is_plane;
      logic                      bin_found;
      logic [INDEX_OUT_BITS-1:0] bin_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FLOOR,
      ST_RANGE,
      ST_READ_OWN,
      ST_READ_PROBE,
      ST_DECIDE,
      ST_INCR
   } state_type;

endpackage

FILE: rtl/core/height_histogram_plane_classifier.sv
// Height histogram plane classifier, top level: sequencer, registers, result stage.
// Depends on hhpc_pkg, hhpc_div and hhpc_mem.
//
//  channel | ports                        | direction | moves
//  --------+------------------------------+-----------+----------------------------------
//  req     | req_valid/req_ready/req_data | in        | accumulate or classify transaction
//  rsp     | rsp_valid/rsp_ready/rsp_data | out       | one result per classify
//  csr     | csr_valid/csr_ready/csr_*    | in        | register write, always ready
//
// An accumulate whose normal fails the tilt test is done in its accept cycle.
// Otherwise the shared divider divides the height magnitude by the bin width, ST_FLOOR
// and ST_RANGE turn the quotient into a floor quotient and then bins and range checks,
// and ST_READ_OWN reads the counter memory; a classify goes on through ST_READ_PROBE and
// ST_DECIDE, an accumulate writes back in ST_INCR unless its bin is out of range.
// One transaction is in flight at a time; req_ready is low meanwhile.
// After reset a clearing sweep zeroes the counter memory, with req_ready low.
// Stalls: a finished result waits in the rsp register; the next transaction is accepted
// while it waits, and only a second result stalls behind it.
module height_histogram_plane_classifier
   import hhpc_pkg::*;
#(
   parameter int MAX_BINS   = 512,
   parameter int COUNT_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int ADDR_BITS = $clog2(MAX_BINS);

   // configuration registers
   logic [WIDTH_BITS-1:0]         bin_width_ff;
   logic signed [OFFSET_BITS-1:0] offset_bins_ff;
   logic [INUSE_BITS-1:0]         bins_in_use_ff;
   logic signed [COS_BITS-1:0]    cos_limit_ff;
   logic [MIN_COUNT_BITS-1:0]     min_count_ff;

   // sequencer and per-transaction state
   state_type                     state_ff, state_in;
   req_type                       item_ff;
   logic signed [QUO_BITS-1:0]    quo_ff;
   logic                          inc_ff;
   logic [ADDR_BITS-1:0]          own_addr_ff;
   logic [ADDR_BITS-1:0]          probe_addr_ff;
   logic [INDEX_OUT_BITS-1:0]     own_index_ff;
   logic                          own_ok_ff;
   logic                          probe_ok_ff;
   logic                          own_hit_ff;

   // result stage
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   // datapath wiring
   logic                          req_fire;
   logic                          clearing;
   logic                          div_start;
   logic                          div_done;
   logic [HEIGHT_BITS-1:0]        div_quo;
   logic [WIDTH_BITS-1:0]         div_rem;
   logic [HEIGHT_BITS-1:0]        height_mag;
   logic [WIDTH_BITS-1:0]         width_eff;
   logic                          tilt_ok;
   logic                          rsp_free;
   logic                          load_rsp;

   logic                          rem_nz;
   logic [QUO_BITS-1:0]           quo_pos;
   logic signed [QUO_BITS-1:0]    quo_in;
   logic [WIDTH_BITS-1:0]         rem_floor;
   logic                          inc_in;

   logic signed [BIN_BITS-1:0]    own_bin;
   logic signed [BIN_BITS-1:0]    probe_bin;
   logic [BIN_BITS-1:0]           own_u;
   logic [BIN_BITS-1:0]           probe_u;
   logic [BIN_BITS-1:0]           limit;

   logic [ADDR_BITS-1:0]          rd_addr;
   logic [COUNT_BITS-1:0]         rd_data;
   logic                          wr_en;
   logic [COUNT_BITS-1:0]         wr_data;
   logic                          count_hit;
   logic                          probe_hit;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff   <= RST_BIN_WIDTH;
         offset_bins_ff <= RST_OFFSET_BINS;
         bins_in_use_ff <= RST_BINS_IN_USE;
         cos_limit_ff   <= RST_COS_LIMIT;
         min_count_ff   <= RST_MIN_COUNT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BIN_WIDTH:   bin_width_ff   <= csr_data[WIDTH_BITS-1:0];
            CSR_OFFSET_BINS: offset_bins_ff <= csr_data[OFFSET_BITS-1:0];
            CSR_BINS_IN_USE: bins_in_use_ff <= csr_data[INUSE_BITS-1:0];
            CSR_COS_LIMIT:   cos_limit_ff   <= csr_data[COS_BITS-1:0];
            CSR_MIN_COUNT:   min_count_ff   <= csr_data[MIN_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- shared units ----------------
   // zero width is taken as one
   assign width_eff = (bin_width_ff == '0) ? WIDTH_BITS'(1) : bin_width_ff;

   // magnitude of the incoming height; the most negative value still fits unsigned
   assign height_mag = req_data.height[HEIGHT_BITS-1] ? (~req_data.height + HEIGHT_BITS'(1))
                                                      : req_data.height;

   hhpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (height_mag),
      .divisor   (width_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   hhpc_mem #(
      .DEPTH (MAX_BINS),
      .WIDTH (COUNT_BITS)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (own_addr_ff),
      .wr_data  (wr_data),
      .clearing (clearing)
   );

   // ---------------- floor quotient and half-bin carry ----------------
   // height = q*w + r with 0 <= r < w; the probe bin is one above the own bin when r + w/2 >= w.
   always_comb begin
      rem_nz    = |div_rem;
      quo_pos   = {1'b0, div_quo};
      if (item_ff.height[HEIGHT_BITS-1]) begin
         quo_in    = QUO_BITS'('0) - quo_pos - QUO_BITS'(rem_nz);
         rem_floor = rem_nz ? (width_eff - div_rem) : div_rem;
      end else begin
         quo_in    = quo_pos;
         rem_floor = div_rem;
      end
      inc_in = ({1'b0, rem_floor} + {2'b00, bin_width_ff[WIDTH_BITS-1:1]})
               >= {1'b0, width_eff};
   end

   // ---------------- bin numbers and range ----------------
   always_comb begin
      own_bin   = BIN_BITS'(quo_ff) + BIN_BITS'(offset_bins_ff);
      probe_bin = own_bin + BIN_BITS'(inc_ff);
      own_u     = own_bin;
      probe_u   = probe_bin;
      limit     = (BIN_BITS'(bins_in_use_ff) > BIN_BITS'(MAX_BINS)) ? BIN_BITS'(MAX_BINS)
                                                                    : BIN_BITS'(bins_in_use_ff);
   end

   // ---------------- counter tests ----------------
   assign count_hit = 32'(rd_data) >= 32'(min_count_ff);
   assign probe_hit = probe_ok_ff && count_hit;
   assign wr_data   = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + COUNT_BITS'(1);

   // ---------------- sequencer ----------------
   assign tilt_ok   = item_ff.normal_up >= cos_limit_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !clearing;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rd_addr   = probe_addr_ff;
      wr_en     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // tilted normals on accumulate leave the histogram untouched
            if (req_fire && ((req_data.kind == KIND_CLASSIFY) ||
                             (req_data.normal_up >= cos_limit_ff))) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FLOOR;
            end
         end
         ST_FLOOR: begin
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            state_in = ST_READ_OWN;
         end
         ST_READ_OWN: begin
            rd_addr = own_addr_ff;
            if (item_ff.kind == KIND_CLASSIFY) begin
               state_in = ST_READ_PROBE;
            end else if (own_ok_ff && tilt_ok) begin
               state_in = ST_INCR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_INCR: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ_PROBE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // probe count is held in rd_data while the result stage is full
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-transaction registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_FLOOR) begin
         quo_ff <= quo_in;
         inc_ff <= inc_in;
      end
      if (state_ff == ST_RANGE) begin
         own_ok_ff     <= !own_bin[BIN_BITS-1] && (own_u < limit);
         probe_ok_ff   <= !probe_bin[BIN_BITS-1] && (probe_u < limit);
         own_addr_ff   <= own_u[ADDR_BITS-1:0];
         probe_addr_ff <= probe_u[ADDR_BITS-1:0];
         own_index_ff  <= own_u[INDEX_OUT_BITS-1:0];
      end
      if (state_ff == ST_READ_PROBE) begin
         own_hit_ff <= own_ok_ff && count_hit;
      end
   end

   // ---------------- result stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.is_plane  <= own_hit_ff || probe_hit;
         rsp_data_ff.bin_found <= own_ok_ff;
         rsp_data_ff.bin_index <= own_ok_ff ? own_index_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/hhpc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hhpc_pkg.
module hhpc_div
   import hhpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [HEIGHT_BITS-1:0] dividend,
   input  logic [WIDTH_BITS-1:0]  divisor,
   output logic                   done,
   output logic [HEIGHT_BITS-1:0] quotient,
   output logic [WIDTH_BITS-1:0]  remainder
);

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [HEIGHT_BITS-1:0]  quo_ff;
   logic [WIDTH_BITS-1:0]   rem_ff;
   logic [WIDTH_BITS-1:0]   dvs_ff;

   logic [WIDTH_BITS:0]     shifted;
   logic                    take;
   logic [WIDTH_BITS-1:0]   rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[HEIGHT_BITS-1]};
      take    = shifted >= {1'b0, dvs_ff};
      rem_in  = take ? WIDTH_BITS'(shifted - {1'b0, dvs_ff}) : shifted[WIDTH_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == DIV_CNT_BITS'(HEIGHT_BITS - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(HEIGHT_BITS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[HEIGHT_BITS-2:0], take};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/hhpc_mem.sv
// Bin counter memory: one read port with registered data, one write port,
// and a clearing sweep after reset. Depends on hhpc_pkg.
module hhpc_mem
   import hhpc_pkg::*;
#(
   parameter int DEPTH = 512,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic                     clearing
);

   localparam int ADDR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]     counts_ff [DEPTH];
   logic [WIDTH-1:0]     rd_data_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic                 clearing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         if (clr_addr_ff == ADDR_BITS'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         counts_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         counts_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= counts_ff[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule
